FILE: src/sbr_pkg.sv
// ---------------------------------------------------------------------------
// sbr_pkg - shared definitions for the buffered SPI master
// Register offsets, error codes, controller states and buffer sizing.
// ---------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

  localparam int BUFFER_DEPTH   = 256;
  localparam int ADDR_W         = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int LENGTH_LIMIT   = (BUFFER_DEPTH < 511) ? BUFFER_DEPTH : 511;
  localparam int PTR_W          = 16;
  localparam int LEN_W          = 9;
  localparam int CD_W           = 12;
  localparam int DATA_W         = 16;
  localparam int BYTE_W         = 8;

  localparam logic [DATA_W-1:0] START_VALUE = 16'h0001;

  typedef enum logic [1:0] {
    OFF_DATA    = 2'd0,
    OFF_POINTER = 2'd1,
    OFF_STATUS  = 2'd2,
    OFF_SIZE    = 2'd3
  } offset_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BUSY   = 2'd1,
    ERR_STATUS = 2'd2,
    ERR_RANGE  = 2'd3
  } err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Buffer address from a 16-bit pointer or index value.
  function automatic logic [ADDR_W-1:0] to_addr(input logic [PTR_W-1:0] value);
    return value[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/sbr_if.sv
// ---------------------------------------------------------------------------
// sbr_req_if / sbr_rsp_if - valid/ready channels of the buffered SPI master
// One bus cycle item in, one result item out.
// ---------------------------------------------------------------------------
`default_nettype none

interface sbr_req_if;
  logic        valid;
  logic        ready;
  logic        read_valid;
  logic [1:0]  read_offset;
  logic        write_valid;
  logic [1:0]  write_offset;
  logic [15:0] write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, read_valid, read_offset, write_valid, write_offset,
                  write_data, rx_byte, input ready);
  modport sink   (input valid, read_valid, read_offset, write_valid, write_offset,
                  write_data, rx_byte, output ready);
endinterface

interface sbr_rsp_if;
  logic        valid;
  logic        ready;
  logic        read_data_valid;
  logic [15:0] read_data;
  logic [1:0]  error_code;
  logic        tx_valid;
  logic [7:0]  tx_byte;

  modport source (output valid, read_data_valid, read_data, error_code, tx_valid,
                  tx_byte, input ready);
  modport sink   (input valid, read_data_valid, read_data, error_code, tx_valid,
                  tx_byte, output ready);
endinterface

`default_nettype wire

FILE: src/sbr_ram.sv
// ---------------------------------------------------------------------------
// sbr_ram - simple dual-port RAM, one write and one registered read port
// A read and a write to the same address in one cycle return the old data.
// ---------------------------------------------------------------------------
`default_nettype none

module sbr_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: src/spi_master_buffered_registers_top.sv
// ---------------------------------------------------------------------------
// spi_master_buffered_registers_top - SPI master behind four bus registers
// Data, pointer, status and size registers over a byte buffer memory.
// ---------------------------------------------------------------------------
// Each bus cycle item passes the idle, then the execute state: in the
// accepting cycle all register updates and the buffer write are made and
// the buffer memory is read; in the execute state the registered read data
// is merged into the result, which is then loaded into the output register.
// No new item is taken until that load. While the output register is full
// and not taken, the block holds in the execute state. The buffer has no
// reset and needs no clearing pass; reading a byte that was never written
// gives an undefined value.
`default_nettype none

module spi_master_buffered_registers_top (
  input wire logic clk,
  input wire logic rst,
  sbr_req_if.sink  req,
  sbr_rsp_if.source rsp
);

  sbr_pkg::state_t state, state_next;

  logic [sbr_pkg::PTR_W-1:0] ptr, ptr_next;
  logic [sbr_pkg::LEN_W-1:0] len, len_next;
  logic [sbr_pkg::CD_W-1:0]  cd, cd_next;

  // Per-item results held from the accepting cycle until the output load.
  logic                       x_rvalid, x_rmem, x_txv;
  logic [sbr_pkg::DATA_W-1:0] x_rdata;
  sbr_pkg::err_t              x_err;

  logic                       rvalid_c, rmem_c, txv_c;
  logic [sbr_pkg::DATA_W-1:0] rdata_c;
  sbr_pkg::err_t              err_c;

  logic                        out_valid;
  logic                        accept, load_out;

  logic                        ram_we, ram_re;
  logic [sbr_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [sbr_pkg::BYTE_W-1:0]  ram_wdata, ram_rdata;

  logic                        busy, xfer, rd, wr, rd_data_ok, wr_data_ok;
  logic [sbr_pkg::CD_W-1:0]    cd_dec;
  logic [sbr_pkg::LEN_W-1:0]   done, idx;
  logic [sbr_pkg::PTR_W-1:0]   ptr_rd;
  sbr_pkg::offset_t            roff, woff;

  sbr_ram #(
    .DEPTH  (sbr_pkg::BUFFER_DEPTH),
    .WIDTH  (sbr_pkg::BYTE_W),
    .ADDR_W (sbr_pkg::ADDR_W)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- controller ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      sbr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = sbr_pkg::ST_EXEC;
        end
      end
      sbr_pkg::ST_EXEC: begin
        if (load_out) begin
          state_next = sbr_pkg::ST_IDLE;
        end
      end
      default: state_next = sbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == sbr_pkg::ST_IDLE);
    load_out  = (state == sbr_pkg::ST_EXEC) && (!out_valid || rsp.ready);
  end

  assign accept = req.valid && req.ready;

  // ---------------- register and buffer decode ----------------
  always_comb begin
    roff   = sbr_pkg::offset_t'(req.read_offset);
    woff   = sbr_pkg::offset_t'(req.write_offset);
    busy   = (cd != '0);
    cd_dec = cd - 1'b1;
    done   = cd_dec[sbr_pkg::CD_W-1:3];
    idx    = len - 1'b1 - done;
    // A byte is exchanged after every eighth busy tick.
    xfer   = busy && (cd_dec[2:0] == 3'd0) && (done < len)
             && (13'(idx) < 13'(sbr_pkg::BUFFER_DEPTH));

    rd = req.read_valid && !(busy && roff != sbr_pkg::OFF_STATUS);
    wr = req.write_valid && !busy;

    rd_data_ok = rd && (roff == sbr_pkg::OFF_DATA)
                 && (17'(ptr) < 17'(sbr_pkg::BUFFER_DEPTH));
    ptr_rd     = rd_data_ok ? (ptr + 1'b1) : ptr;
    wr_data_ok = wr && (woff == sbr_pkg::OFF_DATA)
                 && (17'(ptr_rd) < 17'(sbr_pkg::BUFFER_DEPTH));

    ptr_next = ptr_rd;
    len_next = len;
    cd_next  = busy ? cd_dec : cd;
    if (wr_data_ok) begin
      ptr_next = ptr_rd + 1'b1;
    end
    if (wr && woff == sbr_pkg::OFF_POINTER) begin
      ptr_next = req.write_data;
    end
    if (wr && woff == sbr_pkg::OFF_STATUS && req.write_data == sbr_pkg::START_VALUE) begin
      cd_next = {len, 3'b000};
    end
    if (wr && woff == sbr_pkg::OFF_SIZE
        && 17'(req.write_data) <= 17'(sbr_pkg::LENGTH_LIMIT)) begin
      len_next = req.write_data[sbr_pkg::LEN_W-1:0];
    end

    rvalid_c = 1'b0;
    rmem_c   = 1'b0;
    rdata_c  = '0;
    if (rd) begin
      unique case (roff)
        sbr_pkg::OFF_DATA: begin
          rvalid_c = rd_data_ok;
          rmem_c   = rd_data_ok;
        end
        sbr_pkg::OFF_POINTER: begin
          rvalid_c = 1'b1;
          rdata_c  = ptr;
        end
        sbr_pkg::OFF_STATUS: begin
          rvalid_c = 1'b1;
          rdata_c  = {15'd0, busy && (cd_dec != '0)};
        end
        sbr_pkg::OFF_SIZE: begin
          rvalid_c = 1'b1;
          rdata_c  = {7'd0, len};
        end
        default: ;
      endcase
    end
    txv_c = xfer;

    priority if (busy && ((req.read_valid && roff != sbr_pkg::OFF_STATUS)
                          || req.write_valid)) begin
      err_c = sbr_pkg::ERR_BUSY;
    end else if (rd && roff == sbr_pkg::OFF_DATA && !rd_data_ok) begin
      err_c = sbr_pkg::ERR_RANGE;
    end else if (wr && woff == sbr_pkg::OFF_DATA && !wr_data_ok) begin
      err_c = sbr_pkg::ERR_RANGE;
    end else if (wr && woff == sbr_pkg::OFF_STATUS
                 && req.write_data != sbr_pkg::START_VALUE) begin
      err_c = sbr_pkg::ERR_STATUS;
    end else if (wr && woff == sbr_pkg::OFF_SIZE
                 && 17'(req.write_data) > 17'(sbr_pkg::LENGTH_LIMIT)) begin
      err_c = sbr_pkg::ERR_RANGE;
    end else begin
      err_c = sbr_pkg::ERR_NONE;
    end

    // The exchange reads and overwrites the same entry; the memory returns
    // the old byte, which is the one sent out.
    ram_re    = accept && (xfer || rd_data_ok);
    ram_raddr = xfer ? sbr_pkg::to_addr(16'(idx)) : sbr_pkg::to_addr(ptr);
    ram_we    = accept && (xfer || wr_data_ok);
    ram_waddr = xfer ? sbr_pkg::to_addr(16'(idx)) : sbr_pkg::to_addr(ptr_rd);
    ram_wdata = xfer ? req.rx_byte : req.write_data[sbr_pkg::BYTE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbr_pkg::ST_IDLE;
      ptr       <= '0;
      len       <= '0;
      cd        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        ptr <= ptr_next;
        len <= len_next;
        cd  <= cd_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_rvalid <= rvalid_c;
      x_rmem   <= rmem_c;
      x_rdata  <= rdata_c;
      x_err    <= err_c;
      x_txv    <= txv_c;
    end
    if (load_out) begin
      rsp.read_data_valid <= x_rvalid;
      rsp.read_data       <= x_rmem ? {8'd0, ram_rdata} : x_rdata;
      rsp.error_code      <= x_err;
      rsp.tx_valid        <= x_txv;
      rsp.tx_byte         <= x_txv ? ram_rdata : 8'd0;
    end
  end

  assign rsp.valid = out_valid;

  // ---------------- assertions ----------------
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == sbr_pkg::ST_EXEC)
    else $error("accepted item did not move the controller to its second cycle");

  a_countdown_step: assert property (@(posedge clk) disable iff (rst)
    (accept && cd != '0) |=> cd == $past(cd) - 1'b1)
    else $error("busy countdown did not fall by one on a busy item");

  a_exchange_same_entry: assert property (@(posedge clk) disable iff (rst)
    (accept && cd != '0 && ram_we) |-> (ram_re && ram_waddr == ram_raddr))
    else $error("byte exchange wrote an entry other than the one read");

  a_idle_no_ram: assert property (@(posedge clk) disable iff (rst)
    (state == sbr_pkg::ST_EXEC) |-> (!ram_we && !ram_re))
    else $error("buffer accessed outside the accepting cycle");

endmodule

`default_nettype wire

FILE: tb/tb_spi_master_buffered_registers_top.sv
// ---------------------------------------------------------------------------
// tb_spi_master_buffered_registers_top - bus cycle checker for the SPI master
// Drives register reads, register writes and received bytes into the block.
// A behavioural copy of the registers, the buffer and the busy countdown
// predicts every result item, and each result is checked field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_spi_master_buffered_registers_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbr_pkg::*;

  localparam int RANDOM_ITEMS   = 1425;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int REPORT_LIMIT   = 10;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic              rd;
    offset_t           roff;
    logic              wr;
    offset_t           woff;
    logic [DATA_W-1:0] wdata;
    logic [BYTE_W-1:0] rx;
  } bus_cycle_t;

  typedef struct packed {
    logic              rdv;
    logic [DATA_W-1:0] rdata;
    err_t              err;
    logic              txv;
    logic [BYTE_W-1:0] txb;
  } bus_reply_t;

  // Register and buffer predictor with the queue of results still owed.
  class spi_regs_scoreboard;
    logic [BYTE_W-1:0] byte_buffer [BUFFER_DEPTH];
    bit                written [BUFFER_DEPTH];
    logic [PTR_W-1:0]  pointer;
    logic [LEN_W-1:0]  xfer_length;
    logic [CD_W-1:0]   countdown;
    bus_reply_t        expected_replies [$];
    int                mismatches;

    function new();
      pointer     = '0;
      xfer_length = '0;
      countdown   = '0;
      mismatches  = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function bit is_busy();
      return countdown != '0;
    endfunction

    // True when every byte that a transfer of n bytes would send holds data.
    function bit primed(int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        if (!written[i]) return 1'b0;
      return 1'b1;
    endfunction

    function err_t first_error(err_t now, err_t code);
      return (now == ERR_NONE) ? code : now;
    endfunction

    function void note_cycle(bus_cycle_t c);
      bus_reply_t  r;
      logic        rd;
      logic        wr;
      int unsigned done;
      int unsigned idx;
      r  = '0;
      rd = c.rd;
      wr = c.wr;
      if (countdown != '0) begin
        countdown = countdown - 1'b1;
        // Every eighth tick swaps one byte, counting up from index 0.
        if (countdown[2:0] == 3'd0) begin
          done = countdown >> 3;
          if (done < xfer_length) begin
            idx = xfer_length - 1 - done;
            if (idx < BUFFER_DEPTH) begin
              r.txv            = 1'b1;
              r.txb            = byte_buffer[idx];
              byte_buffer[idx] = c.rx;
              written[idx]     = 1'b1;
            end
          end
        end
        if (rd && c.roff != OFF_STATUS) begin
          rd    = 1'b0;
          r.err = ERR_BUSY;
        end
        if (wr) begin
          wr    = 1'b0;
          r.err = ERR_BUSY;
        end
      end
      if (rd) begin
        case (c.roff)
          OFF_DATA: begin
            if (pointer < BUFFER_DEPTH) begin
              r.rdv   = 1'b1;
              r.rdata = {8'h00, byte_buffer[pointer]};
              pointer = pointer + 1'b1;
            end else begin
              r.err = first_error(r.err, ERR_RANGE);
            end
          end
          OFF_POINTER: begin
            r.rdv   = 1'b1;
            r.rdata = pointer;
          end
          OFF_STATUS: begin
            r.rdv   = 1'b1;
            r.rdata = (countdown != '0) ? 16'd1 : 16'd0;
          end
          default: begin
            r.rdv   = 1'b1;
            r.rdata = DATA_W'(xfer_length);
          end
        endcase
      end
      if (wr) begin
        case (c.woff)
          OFF_DATA: begin
            if (pointer < BUFFER_DEPTH) begin
              byte_buffer[pointer] = c.wdata[BYTE_W-1:0];
              written[pointer]     = 1'b1;
              pointer              = pointer + 1'b1;
            end else begin
              r.err = first_error(r.err, ERR_RANGE);
            end
          end
          OFF_POINTER: pointer = c.wdata;
          OFF_STATUS: begin
            if (c.wdata == START_VALUE) countdown = {xfer_length, 3'b000};
            else r.err = first_error(r.err, ERR_STATUS);
          end
          default: begin
            if (c.wdata <= LENGTH_LIMIT) xfer_length = c.wdata[LEN_W-1:0];
            else r.err = first_error(r.err, ERR_RANGE);
          end
        endcase
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(bus_reply_t got);
      bus_reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result item with none expected: rdv=%0b data=%h err=%0d tx=%0b/%h",
                   got.rdv, got.rdata, got.err, got.txv, got.txb);
        return;
      end
      want = expected_replies.pop_front();
      if (got.rdv !== want.rdv || got.rdata !== want.rdata || got.err !== want.err ||
          got.txv !== want.txv || got.txb !== want.txb) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("ERROR: expected rdv=%0b data=%h err=%0d tx=%0b/%h",
                   want.rdv, want.rdata, want.err, want.txv, want.txb);
          $display("       got      rdv=%0b data=%h err=%0d tx=%0b/%h",
                   got.rdv, got.rdata, got.err, got.txv, got.txb);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sbr_req_if req_ch ();
  sbr_rsp_if rsp_ch ();

  spi_master_buffered_registers_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  spi_regs_scoreboard board;
  int items_sent    = 0;
  int replies_seen  = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;

  function automatic bus_cycle_t make_cycle(logic rd, offset_t roff, logic wr, offset_t woff,
                                            logic [DATA_W-1:0] wdata, logic [BYTE_W-1:0] rx);
    bus_cycle_t c;
    c.rd    = rd;
    c.roff  = roff;
    c.wr    = wr;
    c.woff  = woff;
    c.wdata = wdata;
    c.rx    = rx;
    return c;
  endfunction

  function automatic bus_cycle_t random_cycle();
    bus_cycle_t c;
    c.rd   = 1'($urandom_range(0, 1));
    c.roff = offset_t'($urandom_range(0, 3));
    c.wr   = 1'($urandom_range(0, 1));
    c.woff = offset_t'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       c.wdata = START_VALUE;
      1:       c.wdata = 16'($urandom_range(0, 300));
      default: c.wdata = 16'($urandom);
    endcase
    c.rx = 8'($urandom);
    return c;
  endfunction

  // Keeps the bus away from buffer bytes that hold no data yet: such a data
  // read becomes a size read, and such a start becomes a bad status value.
  function automatic bus_cycle_t legalise(bus_cycle_t c);
    if (!board.is_busy()) begin
      if (c.rd && c.roff == OFF_DATA && board.pointer < BUFFER_DEPTH &&
          !board.written[board.pointer[ADDR_W-1:0]])
        c.roff = OFF_SIZE;
      if (c.wr && c.woff == OFF_STATUS && c.wdata == START_VALUE &&
          !board.primed(board.xfer_length))
        c.wdata = 16'h0002;
    end
    return c;
  endfunction

  task automatic send_cycle(bus_cycle_t c);
    bus_cycle_t legal;
    int         gap;
    legal = legalise(c);
    req_ch.valid        <= 1'b1;
    req_ch.read_valid   <= legal.rd;
    req_ch.read_offset  <= legal.roff;
    req_ch.write_valid  <= legal.wr;
    req_ch.write_offset <= legal.woff;
    req_ch.write_data   <= legal.wdata;
    req_ch.rx_byte      <= legal.rx;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_cycle(legal);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic reg_write(offset_t off, logic [DATA_W-1:0] value);
    send_cycle(make_cycle(1'b0, OFF_DATA, 1'b1, off, value, 8'($urandom)));
  endtask

  task automatic reg_read(offset_t off);
    send_cycle(make_cycle(1'b1, off, 1'b0, OFF_DATA, 16'($urandom), 8'($urandom)));
  endtask

  task automatic run_directed();
    reg_read(OFF_STATUS);
    reg_read(OFF_POINTER);
    send_cycle(make_cycle(1'b0, OFF_DATA, 1'b1, OFF_DATA, 16'hABCD, 8'hFF));
    send_cycle(make_cycle(1'b1, OFF_SIZE, 1'b1, OFF_DATA, 16'hFFFF, 8'h00));
    // The read sees the pointer before the write moves it on.
    send_cycle(make_cycle(1'b1, OFF_POINTER, 1'b1, OFF_DATA, 16'h0000, 8'hFF));
    reg_write(OFF_POINTER, 16'h0000);
    send_cycle(make_cycle(1'b1, OFF_DATA, 1'b1, OFF_DATA, 16'h5A5A, 8'h00));
    reg_read(OFF_DATA);
    reg_write(OFF_SIZE, 16'd257);
    reg_write(OFF_SIZE, 16'hFFFF);
    reg_write(OFF_SIZE, 16'(LENGTH_LIMIT));
    reg_read(OFF_SIZE);
    reg_write(OFF_STATUS, 16'h0000);
    reg_write(OFF_STATUS, 16'hFFFF);
    reg_write(OFF_SIZE, 16'd0);
    // A zero size start gives no busy period at all.
    send_cycle(make_cycle(1'b1, OFF_STATUS, 1'b1, OFF_STATUS, START_VALUE, 8'h00));
    reg_read(OFF_STATUS);
    reg_write(OFF_POINTER, 16'hFFFF);
    send_cycle(make_cycle(1'b1, OFF_DATA, 1'b1, OFF_DATA, 16'h1234, 8'hFF));
    reg_write(OFF_POINTER, 16'd256);
    send_cycle(make_cycle(1'b1, OFF_POINTER, 1'b1, OFF_DATA, 16'h00FF, 8'h00));
    reg_write(OFF_SIZE, 16'd3);
    reg_write(OFF_POINTER, 16'h0000);
    reg_write(OFF_STATUS, START_VALUE);
    send_cycle(make_cycle(1'b1, OFF_STATUS, 1'b1, OFF_SIZE, 16'd5, 8'hFF));
    reg_read(OFF_DATA);
    reg_read(OFF_SIZE);
  endtask

  task automatic seq_fill();
    int         n;
    bus_cycle_t c;
    n = $urandom_range(1, 24);
    reg_write(OFF_POINTER, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 255)));
    repeat (n) begin
      c = make_cycle(1'b0, offset_t'($urandom_range(0, 3)), 1'b1, OFF_DATA,
                     16'($urandom), 8'($urandom));
      c.rd = ($urandom_range(0, 3) == 0);
      send_cycle(c);
    end
  endtask

  task automatic seq_readback(logic [DATA_W-1:0] start, int n);
    reg_write(OFF_POINTER, start);
    repeat (n) reg_read(OFF_DATA);
  endtask

  task automatic seq_transfer();
    int n;
    int polls;
    case ($urandom_range(0, 11))
      0:       n = 0;
      1:       n = $urandom_range(9, 48);
      default: n = $urandom_range(1, 8);
    endcase
    if (!board.primed(n)) begin
      reg_write(OFF_POINTER, 16'd0);
      repeat (n) reg_write(OFF_DATA, 16'($urandom));
    end
    reg_write(OFF_SIZE, 16'(n));
    send_cycle(make_cycle(1'($urandom_range(0, 1)), OFF_STATUS, 1'b1, OFF_STATUS,
                          START_VALUE, 8'($urandom)));
    // Poll status through the busy period, with stray accesses now and then.
    polls = n * 8 + $urandom_range(0, 3);
    repeat (polls) begin
      if ($urandom_range(0, 5) == 0) send_cycle(random_cycle());
      else reg_read(OFF_STATUS);
    end
    if (n > 0) seq_readback(16'd0, n);
  endtask

  task automatic seq_noise();
    repeat ($urandom_range(1, 20)) send_cycle(random_cycle());
  endtask

  task automatic seq_out_of_range();
    reg_write(OFF_POINTER, 16'($urandom_range(BUFFER_DEPTH, 65535)));
    repeat ($urandom_range(1, 4)) begin
      send_cycle(make_cycle(1'($urandom_range(0, 1)), OFF_DATA, 1'($urandom_range(0, 1)),
                            OFF_DATA, 16'($urandom), 8'($urandom)));
    end
    reg_read(OFF_POINTER);
    reg_write(OFF_SIZE, ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                        16'($urandom_range(LENGTH_LIMIT - 2, LENGTH_LIMIT + 2)));
    reg_read(OFF_SIZE);
  endtask

  initial begin : stimulus
    int directed_count;
    board = new();
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.read_valid   <= 1'b0;
    req_ch.read_offset  <= OFF_DATA;
    req_ch.write_valid  <= 1'b0;
    req_ch.write_offset <= OFF_DATA;
    req_ch.write_data   <= '0;
    req_ch.rx_byte      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    directed_count = items_sent;
    while (items_sent - directed_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: seq_fill();
        3:       seq_readback(16'($urandom_range(0, 255)), $urandom_range(1, 16));
        4, 5, 6: seq_transfer();
        7:       seq_noise();
        default: seq_out_of_range();
      endcase
    end
    req_ch.valid <= 1'b0;
    while (board.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // The receiver changes its stall pattern in runs, and once holds off long
  // enough for the block to fill up and stop taking items.
  initial begin : receiver
    int mode;
    int run_len;
    int step;
    bit held;
    held = 1'b0;
    step = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (!held && replies_seen >= 300) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          rsp_ch.ready <= 1'b0;
        end
      end
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(4, 64);
      repeat (run_len) begin
        @(posedge clk);
        step++;
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       rsp_ch.ready <= (step % 4 != 3);
          default: rsp_ch.ready <= (step % 7 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    bus_reply_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.rdv   = rsp_ch.read_data_valid;
      got.rdata = rsp_ch.read_data;
      got.err   = err_t'(rsp_ch.error_code);
      got.txv   = rsp_ch.tx_valid;
      got.txb   = rsp_ch.tx_byte;
      board.check_reply(got);
      replies_seen++;
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
